// File: design/sobel_edge_magnitude_core_defines.svh
// Assertion macros shared by the edge magnitude core.
// Each check samples on the rising edge of clock and is off while reset is high.
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_DEFINES_SVH

// Same-cycle implication or plain property.
`define SEM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Condition in this cycle, expectation in the next.
`define SEM_ASSERT_NEXT(label, cond, want, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (want)) \
      else $error(msg);

`endif

// File: design/sem_pkg.sv
`default_nettype none

package sem_pkg;

   localparam int SUM_W  = 10;
   localparam int GRAD_W = 13;
   localparam int SQ_W   = 24;
   localparam int MAG2_W = 25;

   localparam logic [11:0]       FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [15:0]       FRAME_HEIGHT_RESET = 16'd480;
   localparam logic [MAG2_W-1:0] SAT_LIMIT          = 25'd65025;
   localparam logic [7:0]        MAG_SAT            = 8'd255;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0]  edge_magnitude;
      logic [10:0] out_column;
      logic [15:0] out_row;
      logic        frame_last;
   } rsp_type;

   // One line store entry: intensity two rows up and one row up.
   typedef struct packed {
      logic [SUM_W-1:0] upper;
      logic [SUM_W-1:0] middle;
   } line_entry_type;

   // New column entering the window.
   typedef struct packed {
      logic             shift;
      logic [SUM_W-1:0] upper;
      logic [SUM_W-1:0] middle;
      logic [SUM_W-1:0] bottom;
   } window_in_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      logic [7:0] root;
   } root_status_type;

endpackage

`default_nettype wire

// File: design/sobel_edge_magnitude_core.sv
// Channel  | Handshake             | Word
// ---------+-----------------------+--------------------------------------------------
// req      | req_valid/req_ready   | req_type: r, g, b, frame_start (raster order)
// rsp      | rsp_valid/rsp_ready   | rsp_type: magnitude, column, row, frame_last
// csr      | csr_write_enable      | csr_index selects width/height, csr_write_data
//
// Each word is handled alone: a border pixel only passes accept and the line store read.
// An interior pixel then runs the gradient, square, sum and root steps; when the magnitude
// saturates it skips the bit-serial square root (one result bit per cycle).
// The result sits in an output register, so the next word is taken while it waits.
// A stalled rsp side holds the core after the next interior pixel until rsp_ready.
// Reset is synchronous; the line stores are not cleared and need no clearing pass.
`default_nettype none
`include "sobel_edge_magnitude_core_defines.svh"

module sobel_edge_magnitude_core #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  sem_pkg::req_type       req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output sem_pkg::rsp_type       rsp_payload,
   input  wire                    csr_write_enable,
   input  sem_pkg::csr_index_type csr_index,
   input  wire  [15:0]            csr_write_data
);
   import sem_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam logic [13:0] MAX_WIDTH_EXT = 14'(MAX_WIDTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_GRAD,
      S_SQUARE,
      S_SUM,
      S_ROOT,
      S_WAIT,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [11:0] frame_width_ff;
   logic [15:0] frame_height_ff;
   logic [CW-1:0] col_cnt_ff;
   logic [15:0]   row_cnt_ff;

   logic [AW-1:0]    col_ff;
   logic [15:0]      row_ff;
   logic [SUM_W-1:0] sum_ff;

   logic [10:0] out_col_ff, out_col_in;
   logic [15:0] out_row_ff, out_row_in;
   logic        last_ff, last_in;
   logic [7:0]  mag_ff, mag_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_payload_ff, rsp_payload_in;

   logic [13:0]   width_ext, width_clamp;
   logic [CW-1:0] eff_w;
   logic [15:0]   eff_h;
   logic          accept;
   logic [CW-1:0] col_start, col_cur;
   logic [15:0]   row_start, row_step, row_cur;
   logic          col_wrap;
   logic [SUM_W-1:0] pix_sum;
   logic [12:0]   col_ext;
   logic          emit;

   line_entry_type    ls_rd_data, ls_wr_data;
   logic              ls_rd_en, ls_wr_en;
   window_in_type     win_in;
   logic [MAG2_W-1:0] mag2;
   logic              iq_start;
   root_status_type   iq_status;

   // Effective frame size: width clamped to 3..MAX_WIDTH, height at least 3.
   assign width_ext   = 14'(frame_width_ff);
   assign width_clamp = (width_ext < 14'd3) ? 14'd3 :
                        (width_ext > MAX_WIDTH_EXT) ? MAX_WIDTH_EXT : width_ext;
   assign eff_w       = CW'(width_clamp);
   assign eff_h       = (frame_height_ff < 16'd3) ? 16'd3 : frame_height_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Position of the incoming word: frame_start restarts, end of row and end of
   // frame wrap before use (also after a size change).
   assign col_start = req_payload.frame_start ? '0 : col_cnt_ff;
   assign row_start = req_payload.frame_start ? '0 : row_cnt_ff;
   assign col_wrap  = (col_start >= eff_w);
   assign col_cur   = col_wrap ? '0 : col_start;
   assign row_step  = col_wrap ? row_start + 16'd1 : row_start;
   assign row_cur   = (row_step >= eff_h) ? '0 : row_step;
   assign pix_sum   = SUM_W'(req_payload.pixel_red) + SUM_W'(req_payload.pixel_green)
                    + SUM_W'(req_payload.pixel_blue);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         col_cnt_ff      <= '0;
         row_cnt_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data[11:0];
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (accept) begin
            col_cnt_ff <= col_cur + CW'(1);
            row_cnt_ff <= row_cur;
         end
      end
   end

   // Hold the position and intensity of the word in flight.
   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff <= AW'(col_cur);
         row_ff <= row_cur;
         sum_ff <= pix_sum;
      end
   end

   // Line store: read at accept, write back in the cycle after. The next word is
   // only taken after the write, so no two accesses to one entry overlap.
   assign ls_rd_en   = accept;
   assign ls_wr_en   = (state_ff == S_READ);
   assign ls_wr_data = '{upper: ls_rd_data.middle, middle: sum_ff};

   sem_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (ls_rd_en),
      .rd_addr (AW'(col_cur)),
      .rd_data (ls_rd_data),
      .wr_en   (ls_wr_en),
      .wr_addr (col_ff),
      .wr_data (ls_wr_data)
   );

   assign win_in = '{shift:  (state_ff == S_READ),
                     upper:  ls_rd_data.upper,
                     middle: ls_rd_data.middle,
                     bottom: sum_ff};

   sem_gradient u_gradient (
      .clock  (clock),
      .reset  (reset),
      .win_in (win_in),
      .mag2   (mag2)
   );

   assign iq_start = (state_ff == S_ROOT) && (mag2 < SAT_LIMIT);

   sem_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (iq_start),
      .value  (mag2[15:0]),
      .status (iq_status)
   );

   assign col_ext = 13'(col_ff);
   assign emit    = (col_ff >= AW'(2)) && (row_ff >= 16'd2);

   always_comb begin
      state_in       = state_ff;
      out_col_in     = out_col_ff;
      out_row_in     = out_row_ff;
      last_in        = last_ff;
      mag_in         = mag_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            // Result refers to the pixel up-left of this one.
            out_col_in = 11'(col_ext - 13'd1);
            out_row_in = row_ff - 16'd1;
            last_in    = (col_ext == 13'(eff_w) - 13'd1) && (row_ff == eff_h - 16'd1);
            state_in   = emit ? S_GRAD : S_IDLE;
         end
         S_GRAD:   state_in = S_SQUARE;
         S_SQUARE: state_in = S_SUM;
         S_SUM:    state_in = S_ROOT;
         S_ROOT: begin
            if (mag2 >= SAT_LIMIT) begin
               mag_in   = MAG_SAT;
               state_in = S_OUT;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (iq_status.done) begin
               mag_in   = iq_status.root;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = '{edge_magnitude: mag_ff, out_column: out_col_ff,
                                  out_row: out_row_ff, frame_last: last_ff};
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_col_ff     <= out_col_in;
      out_row_ff     <= out_row_in;
      last_ff        <= last_in;
      mag_ff         <= mag_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `SEM_ASSERT_NEXT(a_write_after_read, ls_rd_en, ls_wr_en, "line store read without write-back")
   `SEM_ASSERT(a_interior_only, rsp_valid_ff |-> (rsp_payload_ff.out_column != 11'd0 && rsp_payload_ff.out_row != 16'd0), "border pixel emitted")
   `SEM_ASSERT(a_idle_root_free, (state_ff == S_IDLE) |-> !iq_status.busy, "root unit busy while idle")

endmodule

`default_nettype wire

// File: design/sem_line_store.sv
`default_nettype none

module sem_line_store #(
   parameter int DEPTH = 2048
) (
   input  wire                                clock,
   input  wire                                rd_en,
   input  wire  [$clog2(DEPTH)-1:0]           rd_addr,
   output sem_pkg::line_entry_type            rd_data,
   input  wire                                wr_en,
   input  wire  [$clog2(DEPTH)-1:0]           wr_addr,
   input  sem_pkg::line_entry_type            wr_data
);
   import sem_pkg::*;

   line_entry_type mem [DEPTH];
   line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/sem_gradient.sv
`default_nettype none

module sem_gradient (
   input  wire                              clock,
   input  wire                              reset,
   input  sem_pkg::window_in_type           win_in,
   output logic [sem_pkg::MAG2_W-1:0]       mag2
);
   import sem_pkg::*;

   logic [SUM_W-1:0]         window_ff [9];
   logic [SUM_W-1:0]         window_in [9];
   logic signed [GRAD_W-1:0] q [9];
   logic signed [GRAD_W-1:0] gx_in, gy_in, gx_ff, gy_ff;
   logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   logic [MAG2_W-1:0]        mag2_ff;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         window_in[k] = window_ff[k];
      end
      if (win_in.shift) begin
         for (int k = 0; k < 3; k++) begin
            window_in[3*k]     = window_ff[3*k + 1];
            window_in[3*k + 1] = window_ff[3*k + 2];
         end
         window_in[2] = win_in.upper;
         window_in[5] = win_in.middle;
         window_in[8] = win_in.bottom;
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         q[k] = $signed({{(GRAD_W-SUM_W){1'b0}}, window_ff[k]});
      end
      gx_in = q[6] + (q[7] <<< 1) + q[8] - q[0] - (q[1] <<< 1) - q[2];
      gy_in = q[2] + (q[5] <<< 1) + q[8] - q[0] - (q[3] <<< 1) - q[6];
   end

   assign gx_sq = gx_ff * gx_ff;
   assign gy_sq = gy_ff * gy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            window_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < 9; k++) begin
            window_ff[k] <= window_in[k];
         end
      end
   end

   // Gradient, squares and sum: one register after each step.
   always_ff @(posedge clock) begin
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      sqx_ff  <= SQ_W'(gx_sq);
      sqy_ff  <= SQ_W'(gy_sq);
      mag2_ff <= MAG2_W'(sqx_ff) + MAG2_W'(sqy_ff);
   end

   assign mag2 = mag2_ff;

endmodule

`default_nettype wire

// File: design/sem_isqrt.sv
`default_nettype none
`include "sobel_edge_magnitude_core_defines.svh"

module sem_isqrt (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  wire  [15:0]              value,
   output sem_pkg::root_status_type status
);
   import sem_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [2:0]  step_ff, step_in;
   logic [7:0]  root_ff, root_in;
   logic [15:0] value_ff, value_in;
   logic [7:0]  trial;
   logic [15:0] trial_sq;

   // One result bit per cycle, most significant first.
   assign trial    = root_ff | (8'b1 << step_ff);
   assign trial_sq = 16'(trial) * 16'(trial);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      root_in  = root_ff;
      value_in = value_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = 3'd7;
         root_in  = '0;
         value_in = value;
      end else if (busy_ff) begin
         if (trial_sq <= value_ff) begin
            root_in = trial;
         end
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      root_ff  <= root_in;
      value_ff <= value_in;
   end

   assign status = '{busy: busy_ff, done: done_ff, root: root_ff};

   `SEM_ASSERT(a_root_not_high, done_ff |-> (17'(root_ff) * 17'(root_ff) <= 17'(value_ff)), "root too large")
   `SEM_ASSERT(a_root_not_low, done_ff |-> ((17'(root_ff) + 17'd1) * (17'(root_ff) + 17'd1) > 17'(value_ff)), "root too small")
   `SEM_ASSERT_NEXT(a_start_busy, start, busy_ff && !done_ff, "start did not begin a root")

endmodule

`default_nettype wire
